// ===== sv/sdtn_pkg.sv =====
package sdtn_pkg;

  localparam int unsigned DefFractionBits   = 16;
  localparam int unsigned DefFractionDigits = 5;
  localparam int unsigned DefSeparatorSlots = 4;
  localparam int unsigned DefIndexBits      = 16;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned AccBits    = 47;
  localparam int unsigned ValueW     = 48;
  localparam int unsigned IndexOutW  = 16;
  localparam int unsigned RegCount   = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned InUseW     = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] CfgIdxInUse = CfgIdxW'(RegCount);

  localparam logic [ByteW-1:0]  SepDefault   = 8'd44;
  localparam logic [InUseW-1:0] InUseDefault = 3'd1;

  localparam logic [ByteW-1:0] CharEnd   = 8'h00;
  localparam logic [ByteW-1:0] CharMinus = 8'h2d;
  localparam logic [ByteW-1:0] CharPoint = 8'h2e;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    OP_SKIP,
    OP_MINUS,
    OP_POINT,
    OP_DIGIT,
    OP_SEP,
    OP_END
  } sdtn_op_e;

  typedef struct packed {
    sdtn_op_e    op;
    logic [3:0]  digit;
  } sdtn_item_t;

endpackage

// ===== sv/separated_decimal_text_to_numbers_unit.sv =====
// Streaming decimal text parser: one ASCII byte per transfer in, one signed Q31.16 number per
// token out, with its token index, an end-of-text flag and a saturation flag. A byte of 0 ends the
// text and returns all token state and the index to zero. Sustained rate is one byte per clock
// unless the output stalls; out_valid_o rises once its token's last byte has passed the queue.
// The front stage classifies each byte against the separator registers, a two-entry queue holds
// classified bytes, and the back stage does one multiply-accumulate per digit into a registered
// output, so in_ready_o drops only when the queue has filled behind a stalled output. The user
// writes separator registers through the cfg port only while no text is in flight (unenforced).
module separated_decimal_text_to_numbers_unit #(
  parameter int unsigned FRACTION_BITS   = sdtn_pkg::DefFractionBits,
  parameter int unsigned FRACTION_DIGITS = sdtn_pkg::DefFractionDigits,
  parameter int unsigned SEPARATOR_SLOTS = sdtn_pkg::DefSeparatorSlots,
  parameter int unsigned INDEX_BITS      = sdtn_pkg::DefIndexBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sdtn_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sdtn_pkg::ByteW-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sdtn_pkg::ByteW-1:0]      text_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sdtn_pkg::ValueW-1:0]     number_value_o,
  output logic [sdtn_pkg::IndexOutW-1:0]  token_index_o,
  output logic                            final_token_o,
  output logic                            clipped_o
);
  import sdtn_pkg::*;

  logic       q_full, q_empty, push, pop;
  sdtn_item_t push_item, head;

  sdtn_front #(
    .SEPARATOR_SLOTS(SEPARATOR_SLOTS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .text_valid_i(in_valid_i),
    .text_byte_i,
    .text_ready_o(in_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  sdtn_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  sdtn_back #(
    .FRACTION_BITS  (FRACTION_BITS),
    .FRACTION_DIGITS(FRACTION_DIGITS),
    .INDEX_BITS     (INDEX_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i(q_empty),
    .head_i   (head),
    .pop_o    (pop),
    .out_valid_o,
    .out_ready_i,
    .number_value_o,
    .token_index_o,
    .final_token_o,
    .clipped_o
  );

endmodule

// ===== sv/sdtn_front.sv =====
module sdtn_front #(
  parameter int unsigned SEPARATOR_SLOTS = sdtn_pkg::DefSeparatorSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdtn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdtn_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          text_valid_i,
  input  logic [sdtn_pkg::ByteW-1:0]    text_byte_i,
  output logic                          text_ready_o,
  input  logic                          q_full_i,
  output logic                          push_o,
  output sdtn_pkg::sdtn_item_t          item_o
);
  import sdtn_pkg::*;

  localparam int unsigned NumSep = (SEPARATOR_SLOTS < RegCount) ? SEPARATOR_SLOTS : RegCount;

  logic [ByteW-1:0]  sep_q [NumSep];
  logic [InUseW-1:0] in_use_q;
  logic              at_start_q;
  logic              sep_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSep; i++) begin
        sep_q[i] <= (i == 0) ? SepDefault : '0;
      end
      in_use_q <= InUseDefault;
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumSep; i++) begin
        if (cfg_idx_i == CfgIdxW'(i)) begin
          sep_q[i] <= cfg_data_i;
        end
      end
      if (cfg_idx_i == CfgIdxInUse) begin
        in_use_q <= cfg_data_i[InUseW-1:0];
      end
    end
  end

  always_comb begin
    sep_hit = 1'b0;
    for (int i = 0; i < NumSep; i++) begin
      if ((32'(in_use_q) > i) && (sep_q[i] != '0) && (sep_q[i] == text_byte_i)) begin
        sep_hit = 1'b1;
      end
    end
  end

  always_comb begin
    item_o.digit = text_byte_i[3:0];
    if (text_byte_i == CharEnd) begin
      item_o.op = OP_END;
    end else if (sep_hit) begin
      item_o.op = OP_SEP;
    end else if (at_start_q && text_byte_i == CharMinus) begin
      item_o.op = OP_MINUS;
    end else if (text_byte_i == CharPoint) begin
      item_o.op = OP_POINT;
    end else if (text_byte_i >= CharZero && text_byte_i <= CharNine) begin
      item_o.op = OP_DIGIT;
    end else begin
      item_o.op = OP_SKIP;
    end
  end

  assign text_ready_o = !q_full_i;
  assign push_o       = text_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
    end else if (push_o) begin
      at_start_q <= (item_o.op == OP_SEP) || (item_o.op == OP_END);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (item_o.op == OP_SEP || item_o.op == OP_END) |=> at_start_q)
    else $error("token start not restored after a token end");

endmodule

// ===== sv/sdtn_queue.sv =====
module sdtn_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sdtn_pkg::sdtn_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output sdtn_pkg::sdtn_item_t head_o
);
  import sdtn_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sdtn_item_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ===== sv/sdtn_back.sv =====
module sdtn_back #(
  parameter int unsigned FRACTION_BITS   = sdtn_pkg::DefFractionBits,
  parameter int unsigned FRACTION_DIGITS = sdtn_pkg::DefFractionDigits,
  parameter int unsigned INDEX_BITS      = sdtn_pkg::DefIndexBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  sdtn_pkg::sdtn_item_t            head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sdtn_pkg::ValueW-1:0]     number_value_o,
  output logic [sdtn_pkg::IndexOutW-1:0]  token_index_o,
  output logic                            final_token_o,
  output logic                            clipped_o
);
  import sdtn_pkg::*;

  localparam int unsigned IntW = AccBits - FRACTION_BITS;
  localparam int unsigned PosW = $clog2(FRACTION_DIGITS + 1);

  logic [FRACTION_BITS-1:0] wtab [FRACTION_DIGITS];

  for (genvar g = 0; g < FRACTION_DIGITS; g++) begin : g_wt
    localparam longint unsigned Pow = 64'd10 ** (g + 1);
    localparam longint unsigned Wt  = ((64'd1 << FRACTION_BITS) + Pow / 2) / Pow;
    assign wtab[g] = FRACTION_BITS'(Wt);
  end

  logic [AccBits-1:0]    acc_q;
  logic                  point_q;
  logic [PosW-1:0]       pos_q;
  logic                  minus_q;
  logic [INDEX_BITS-1:0] tokens_q;
  logic                  ovf_q;

  logic                  out_valid_q;
  logic [ValueW-1:0]     number_q;
  logic [IndexOutW-1:0]  index_q;
  logic                  final_q;
  logic                  clipped_q;

  logic                       emits;
  logic [IntW+3:0]            ip10;
  logic                       sat;
  logic [FRACTION_BITS-1:0]   wsel;
  logic [FRACTION_BITS+3:0]   fprod;
  logic [ValueW-1:0]          mag;

  assign emits = (head_i.op == OP_SEP) || (head_i.op == OP_END);
  assign pop_o = !q_empty_i && (!emits || !out_valid_q || out_ready_i);

  assign ip10 = {1'b0, acc_q[AccBits-1:FRACTION_BITS], 3'b000}
              + {3'b000, acc_q[AccBits-1:FRACTION_BITS], 1'b0}
              + (IntW+4)'(head_i.digit);
  assign sat  = |ip10[IntW+3:IntW];

  always_comb begin
    wsel = '0;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      if (pos_q == PosW'(i)) begin
        wsel = wtab[i];
      end
    end
  end

  assign fprod = (FRACTION_BITS+4)'(head_i.digit) * (FRACTION_BITS+4)'(wsel);
  assign mag   = {1'b0, acc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      point_q  <= 1'b0;
      pos_q    <= '0;
      minus_q  <= 1'b0;
      tokens_q <= '0;
      ovf_q    <= 1'b0;
    end else if (pop_o) begin
      unique case (head_i.op)
        OP_MINUS: minus_q <= 1'b1;
        OP_POINT: point_q <= 1'b1;
        OP_DIGIT: begin
          if (!point_q) begin
            acc_q <= {sat ? {IntW{1'b1}} : ip10[IntW-1:0], {FRACTION_BITS{1'b0}}};
            if (sat) begin
              ovf_q <= 1'b1;
            end
          end else if (pos_q < PosW'(FRACTION_DIGITS)) begin
            pos_q <= pos_q + 1'b1;
            acc_q <= acc_q + AccBits'(fprod);
          end
        end
        OP_SEP, OP_END: begin
          acc_q    <= '0;
          point_q  <= 1'b0;
          pos_q    <= '0;
          minus_q  <= 1'b0;
          ovf_q    <= 1'b0;
          tokens_q <= (head_i.op == OP_END) ? '0 : tokens_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && emits) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emits) begin
      number_q  <= minus_q ? (ValueW'(0) - mag) : mag;
      index_q   <= IndexOutW'(tokens_q);
      final_q   <= (head_i.op == OP_END);
      clipped_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign number_value_o = number_q;
  assign token_index_o  = index_q;
  assign final_token_o  = final_q;
  assign clipped_o      = clipped_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.op == OP_END |=> tokens_q == '0 && acc_q == '0)
    else $error("state not cleared after end of text");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && emits |=> out_valid_q)
    else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(pop_o && emits))
    else $error("result overwritten while stalled");

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdtn_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int ItemsTarget = 1450;
  localparam int LongHold    = 300;
  localparam int IdleCycles  = 8;

  localparam logic [CfgIdxW-1:0] IdxSepA  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] IdxSepB  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] IdxSepC  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] IdxSepD  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] IdxInUse = CfgIdxInUse;

  localparam longint unsigned IntMax = (64'd1 << (AccBits - DefFractionBits)) - 64'd1;

  typedef struct packed {
    logic [ValueW-1:0]    value;
    logic [IndexOutW-1:0] index;
    logic                 last_tok;
    logic                 clip;
  } number_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             typed;
    number_t          res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [ByteW-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [ByteW-1:0]     text_byte = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [ValueW-1:0]    number_value;
  logic [IndexOutW-1:0] token_index;
  logic                 final_token;
  logic                 clipped;

  separated_decimal_text_to_numbers_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .text_byte_i    (text_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .number_value_o (number_value),
    .token_index_o  (token_index),
    .final_token_o  (final_token),
    .clipped_o      (clipped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser model state and separator settings
  logic [ByteW-1:0]     sep_reg [RegCount];
  logic [InUseW-1:0]    sep_in_use;
  logic [AccBits-1:0]   mag;
  bit                   past_pt;
  logic [2:0]           frac_pos;
  bit                   neg;
  bit                   tok_start;
  logic [IndexOutW-1:0] tok_count;
  bit                   sat;

  number_t pending_numbers [$];

  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int numbers_checked = 0;
  int clipped_seen = 0;
  int texts_ended = 0;
  int phases = 0;
  int burst_left = 0;
  bit sender_gapless = 0;
  logic hold_go = 1'b0;
  bit hold_done = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  dir_row_t dir_rows [27];

  function automatic longint unsigned frac_weight(input int k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return ((64'd1 << DefFractionBits) + p / 2) / p;
  endfunction

  task automatic clear_token();
    mag       = '0;
    past_pt   = 0;
    frac_pos  = '0;
    neg       = 0;
    tok_start = 1;
    sat       = 0;
  endtask

  task automatic parse_byte(input logic [ByteW-1:0] b, output bit emits, output number_t res);
    int active;
    bit hit;
    longint unsigned ip;
    active = sep_in_use;
    if (active > RegCount) active = RegCount;
    if (active > DefSeparatorSlots) active = DefSeparatorSlots;
    hit = 0;
    for (int i = 0; i < active; i++)
      if (sep_reg[i] != '0 && sep_reg[i] == b) hit = 1;
    emits = (b == CharEnd) || hit;
    res = '0;
    if (emits) begin
      res.value = {1'b0, mag};
      if (neg) res.value = -res.value;
      res.index    = tok_count;
      res.last_tok = (b == CharEnd);
      res.clip     = sat;
      clear_token();
      if (b == CharEnd) tok_count = '0;
      else tok_count = tok_count + 1'b1;
    end else begin
      if (tok_start && b == CharMinus) begin
        neg = 1;
      end else if (b == CharPoint) begin
        past_pt = 1;
      end else if (b >= CharZero && b <= CharNine) begin
        if (!past_pt) begin
          ip = 64'(mag) >> DefFractionBits;
          ip = ip * 10 + 64'(b - CharZero);
          if (ip > IntMax) begin
            ip  = IntMax;
            sat = 1;
          end
          mag = AccBits'(ip << DefFractionBits);
        end else if (frac_pos < DefFractionDigits) begin
          frac_pos = frac_pos + 1'b1;
          mag = mag + AccBits'(64'(b - CharZero) * frac_weight(frac_pos));
        end
      end
      tok_start = 0;
    end
  endtask

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
    errors++;
  endtask

  // sender: bursts with random gaps unless the phase is gapless, one transfer per call
  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed = 1'b0,
                           input number_t typed_res = '0);
    bit emits;
    number_t res;
    if (burst_left == 0) begin
      if (!sender_gapless) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid  <= 1'b1;
    text_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, emits, res);
    if (emits) pending_numbers.push_back(typed ? typed_res : res);
    bytes_sent++;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < RegCount) sep_reg[idx] = data;
    else if (idx == IdxInUse) sep_in_use = data[InUseW-1:0];
  endtask

  task automatic set_separators(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b,
                                input logic [ByteW-1:0] c, input logic [ByteW-1:0] d,
                                input int n);
    cfg_write(IdxSepA, a);
    cfg_write(IdxSepB, b);
    cfg_write(IdxSepC, c);
    cfg_write(IdxSepD, d);
    cfg_write(IdxInUse, ByteW'(n) | (ByteW'($urandom_range(0, 31)) << InUseW));
    if ($urandom_range(0, 2) == 0)
      cfg_write(CfgIdxW'($urandom_range(RegCount + 1, (1 << CfgIdxW) - 1)),
                ByteW'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    phases++;
  endtask

  task automatic wait_idle();
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  function automatic logic [ByteW-1:0] digit_char();
    return CharZero + ByteW'($urandom_range(0, 9));
  endfunction

  function automatic logic [ByteW-1:0] junk_char();
    case ($urandom_range(0, 3))
      0:       return CharPoint;
      1:       return CharMinus;
      default: return ByteW'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pool_sep();
    case ($urandom_range(0, 7))
      0:       return ",";
      1:       return ";";
      2:       return " ";
      3:       return "|";
      4:       return 8'h09;
      5:       return 8'h0a;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pick_sep();
    logic [ByteW-1:0] live [$];
    int active;
    active = sep_in_use;
    if (active > RegCount) active = RegCount;
    for (int i = 0; i < active; i++)
      if (sep_reg[i] != '0) live.push_back(sep_reg[i]);
    if (live.size() == 0) return CharEnd;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic send_token();
    int r;
    bit junk;
    r = $urandom_range(0, 99);
    if (r < 8) return;
    if (r >= 90) begin
      repeat ($urandom_range(1, 8)) send_byte(ByteW'($urandom_range(0, 255)));
      return;
    end
    junk = (r >= 78);
    if ($urandom_range(0, 9) < 4) send_byte(CharMinus);
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6)) begin
      send_byte(digit_char());
      if (junk && $urandom_range(0, 5) == 0) send_byte(junk_char());
    end
    if ($urandom_range(0, 2) != 0) begin
      send_byte(CharPoint);
      repeat ($urandom_range(0, 7)) begin
        send_byte(digit_char());
        if (junk && $urandom_range(0, 5) == 0) send_byte(junk_char());
      end
    end
  endtask

  task automatic run_phase(input int n_bytes);
    int start;
    int ntok;
    start = bytes_sent;
    sender_gapless = ($urandom_range(0, 3) == 0);
    while (bytes_sent - start < n_bytes) begin
      ntok = $urandom_range(1, 10);
      for (int t = 0; t < ntok; t++) begin
        send_token();
        send_byte((t == ntok - 1) ? CharEnd : pick_sep());
      end
    end
    in_valid <= 1'b0;
    wait_idle();
  endtask

  // receiver: changing stall patterns, plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_left = LongHold;
      hold_done = 1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= ($urandom_range(0, 9) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    number_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch("unexpected number", number_value, 0);
      end else begin
        want = pending_numbers.pop_front();
        if (number_value !== want.value) report_mismatch("number_value", number_value, want.value);
        if (token_index !== want.index) report_mismatch("token_index", token_index, want.index);
        if (final_token !== want.last_tok)
          report_mismatch("final_token", final_token, want.last_tok);
        if (clipped !== want.clip) report_mismatch("clipped", clipped, want.clip);
        numbers_checked++;
        if (want.clip) clipped_seen++;
        if (want.last_tok) texts_ended++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d numbers outstanding", cycles,
               pending_numbers.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    sep_reg[0] = SepDefault;
    sep_reg[1] = '0;
    sep_reg[2] = '0;
    sep_reg[3] = '0;
    sep_in_use = InUseDefault;
    clear_token();
    tok_count = '0;

    // empty token, negative zero, point/minus/digit corner cases, saturation at end of text
    dir_rows = '{
      '{",",       1'b1, '{48'h0, 16'd0, 1'b0, 1'b0}},
      '{CharMinus, 1'b0, '0},
      '{"0",       1'b0, '0},
      '{",",       1'b1, '{48'h0, 16'd1, 1'b0, 1'b0}},
      '{"1",       1'b0, '0},
      '{CharPoint, 1'b0, '0},
      '{"2",       1'b0, '0},
      '{CharPoint, 1'b0, '0},
      '{"3",       1'b0, '0},
      '{CharMinus, 1'b0, '0},
      '{"4",       1'b0, '0},
      '{"5",       1'b0, '0},
      '{"6",       1'b0, '0},
      '{"7",       1'b0, '0},
      '{8'hff,     1'b0, '0},
      '{",",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{"9",       1'b0, '0},
      '{CharEnd,   1'b1, '{48'h7fff_ffff_0000, 16'd3, 1'b1, 1'b1}}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
    in_valid <= 1'b0;
    wait_idle();

    set_separators(",", ";", " ", "|", 4);
    hold_go <= 1'b1;
    run_phase(130);
    set_separators(8'hff, 8'h00, "5", CharMinus, 7);
    run_phase(110);
    set_separators(8'h00, 8'h00, 8'h00, 8'h00, 4);
    run_phase(60);
    set_separators(pool_sep(), pool_sep(), pool_sep(), pool_sep(), 0);
    run_phase(60);
    while (bytes_sent < ItemsTarget) begin
      set_separators(pool_sep(), pool_sep(), pool_sep(), pool_sep(), $urandom_range(0, 7));
      run_phase($urandom_range(80, 140));
    end

    repeat (IdleCycles) @(posedge clk);
    $display("%0d text bytes over %0d separator settings, %0d numbers compared",
             bytes_sent, phases + 1, numbers_checked);
    $display("%0d texts completed, %0d saturated tokens, one long output hold-off",
             texts_ended, clipped_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
